### rtl/core/json_envelope_member_scanner_macros.svh
// Assertion helpers for the envelope scanner.
`ifndef JSON_ENVELOPE_MEMBER_SCANNER_MACROS_SVH
`define JSON_ENVELOPE_MEMBER_SCANNER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define JEMS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define JEMS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/jems_pkg.sv
`default_nettype none

package jems_pkg;

    localparam int MAX_FRAME = 65535;
    localparam int MAX_DEPTH = 255;

    localparam int POS_W   = $clog2(MAX_FRAME + 1);
    localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
    localparam int OUT_W   = 16;
    localparam int KEY_W   = 4;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_MALFORMED = 2'd1;
    localparam logic [1:0] STATUS_BOUND     = 2'd2;

    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_RBRACKET  = 8'h5D;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_LF        = 8'h0A;

    localparam logic [KEY_W-1:0] PROVIDER_KEY_CHARS = 4'd8;
    localparam logic [KEY_W-1:0] PAYLOAD_KEY_CHARS  = 4'd7;
    localparam logic [KEY_W-1:0] KEY_LEN_MAX        = 4'd15;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

    function automatic logic [7:0] provider_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h70;
            3'd1:    ch = 8'h72;
            3'd2:    ch = 8'h6F;
            3'd3:    ch = 8'h76;
            3'd4:    ch = 8'h69;
            3'd5:    ch = 8'h64;
            3'd6:    ch = 8'h65;
            default: ch = 8'h72;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] payload_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h70;
            3'd1:    ch = 8'h61;
            3'd2:    ch = 8'h79;
            3'd3:    ch = 8'h6C;
            3'd4:    ch = 8'h6F;
            3'd5:    ch = 8'h61;
            3'd6:    ch = 8'h64;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

### rtl/core/json_envelope_member_scanner.sv
// Scans one byte per cycle while in_stall is low; a new beat can be accepted on every clock it is not stalled.
// The result for a frame is registered and valid in the cycle after its last beat is taken.
// Throughput: one byte per cycle; input stalls only while a result waits stalled.
// Reset (rst_n, async, active low) returns the parser to before the opening brace
// and empties the result register; the parser also clears itself after every frame.
`default_nettype none

`include "json_envelope_member_scanner_macros.svh"

module json_envelope_member_scanner
    import jems_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic [7:0]       data_byte,
    input  wire logic             last_byte,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic [1:0]            status,
    output logic [OUT_W-1:0]      provider_offset,
    output logic [OUT_W-1:0]      provider_length,
    output logic [OUT_W-1:0]      payload_offset,
    output logic [OUT_W-1:0]      payload_length
);

    typedef enum logic [3:0] {
        PH_BEFORE_OPEN,
        PH_MEMBER,
        PH_KEY,
        PH_AFTER_KEY,
        PH_BEFORE_VALUE,
        PH_VALUE,
        PH_AFTER_VALUE,
        PH_AFTER_CLOSE,
        PH_HALT
    } phase_t;

    typedef enum logic [1:0] {
        VK_SCALAR,
        VK_STRING,
        VK_CONTAINER,
        VK_CONT_STRING
    } kind_t;

    phase_t               phase_reg, phase_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic                 esc_reg, esc_next;
    kind_t                kind_reg, kind_next;
    logic [DEPTH_W-1:0]   depth_reg, depth_next;
    logic [KEY_W-1:0]     key_len_reg, key_len_next;
    logic [1:0]           flags_reg, flags_next;
    logic [POS_W-1:0]     vstart_reg, vstart_next;
    logic [POS_W-1:0]     prov_start_reg, prov_start_next;
    logic [POS_W-1:0]     prov_size_reg, prov_size_next;
    logic                 prov_found_reg, prov_found_next;
    logic [POS_W-1:0]     pay_start_reg, pay_start_next;
    logic [POS_W-1:0]     pay_size_reg, pay_size_next;
    logic                 pay_found_reg, pay_found_next;
    logic [1:0]           err_reg, err_next;

    logic                 out_valid_reg, out_valid_next;
    logic [1:0]           status_reg, status_next;
    logic [OUT_W-1:0]     prov_off_reg, prov_off_next;
    logic [OUT_W-1:0]     prov_len_reg, prov_len_next;
    logic [OUT_W-1:0]     pay_off_reg, pay_off_next;
    logic [OUT_W-1:0]     pay_len_reg, pay_len_next;

    logic                 accept;
    logic                 fin_en;
    logic [POS_W-1:0]     fin_end;
    logic [POS_W-1:0]     fin_len;
    logic                 av_en;
    logic [1:0]           fail_code;
    logic [1:0]           frame_status;

    assign in_stall = out_valid_reg & out_stall;
    assign accept   = in_valid & ~in_stall;

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign provider_offset = prov_off_reg;
    assign provider_length = prov_len_reg;
    assign payload_offset  = pay_off_reg;
    assign payload_length  = pay_len_reg;

    always_comb
    begin
        phase_next      = phase_reg;
        pos_next        = pos_reg;
        esc_next        = esc_reg;
        kind_next       = kind_reg;
        depth_next      = depth_reg;
        key_len_next    = key_len_reg;
        flags_next      = flags_reg;
        vstart_next     = vstart_reg;
        prov_start_next = prov_start_reg;
        prov_size_next  = prov_size_reg;
        prov_found_next = prov_found_reg;
        pay_start_next  = pay_start_reg;
        pay_size_next   = pay_size_reg;
        pay_found_next  = pay_found_reg;
        err_next        = err_reg;
        fin_en          = 1'b0;
        fin_end         = pos_reg;
        fin_len         = '0;
        av_en           = 1'b0;
        fail_code       = STATUS_OK;
        frame_status    = STATUS_OK;

        out_valid_next  = out_valid_reg & out_stall;
        status_next     = status_reg;
        prov_off_next   = prov_off_reg;
        prov_len_next   = prov_len_reg;
        pay_off_next    = pay_off_reg;
        pay_len_next    = pay_len_reg;

        if (accept)
        begin
            if (pos_reg >= POS_W'(MAX_FRAME))
            begin
                err_next   = STATUS_BOUND;
                phase_next = PH_HALT;
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
                case (phase_reg)
                    PH_BEFORE_OPEN:
                    begin
                        if (data_byte == CH_LBRACE)
                            phase_next = PH_MEMBER;
                        else if (!is_ws(data_byte))
                            fail_code = STATUS_MALFORMED;
                    end
                    PH_MEMBER:
                    begin
                        if (data_byte == CH_RBRACE)
                            phase_next = PH_AFTER_CLOSE;
                        else if (data_byte == CH_QUOTE)
                        begin
                            phase_next   = PH_KEY;
                            key_len_next = '0;
                            flags_next   = 2'b11;
                            esc_next     = 1'b0;
                        end
                        else if (!is_ws(data_byte))
                            fail_code = STATUS_MALFORMED;
                    end
                    PH_KEY:
                    begin
                        if (!esc_reg && data_byte == CH_QUOTE)
                        begin
                            if (key_len_reg != PROVIDER_KEY_CHARS)
                                flags_next[0] = 1'b0;
                            if (key_len_reg != PAYLOAD_KEY_CHARS)
                                flags_next[1] = 1'b0;
                            phase_next = PH_AFTER_KEY;
                        end
                        else
                        begin
                            esc_next = !esc_reg && data_byte == CH_BACKSLASH;
                            if (key_len_reg >= PROVIDER_KEY_CHARS
                                || provider_char(key_len_reg[2:0]) != data_byte)
                                flags_next[0] = 1'b0;
                            if (key_len_reg >= PAYLOAD_KEY_CHARS
                                || payload_char(key_len_reg[2:0]) != data_byte)
                                flags_next[1] = 1'b0;
                            if (key_len_reg < KEY_LEN_MAX)
                                key_len_next = key_len_reg + KEY_W'(1);
                        end
                    end
                    PH_AFTER_KEY:
                    begin
                        if (data_byte == CH_COLON)
                            phase_next = PH_BEFORE_VALUE;
                        else if (!is_ws(data_byte))
                            fail_code = STATUS_MALFORMED;
                    end
                    PH_BEFORE_VALUE:
                    begin
                        if (!is_ws(data_byte))
                        begin
                            vstart_next = pos_reg;
                            esc_next    = 1'b0;
                            if (data_byte == CH_QUOTE)
                            begin
                                kind_next  = VK_STRING;
                                phase_next = PH_VALUE;
                            end
                            else if (data_byte inside {CH_LBRACE, CH_LBRACKET})
                            begin
                                kind_next  = VK_CONTAINER;
                                depth_next = DEPTH_W'(1);
                                phase_next = PH_VALUE;
                            end
                            else if (data_byte inside {CH_COMMA, CH_RBRACE, CH_RBRACKET})
                            begin
                                kind_next = VK_SCALAR;
                                fin_en    = 1'b1;
                                fin_end   = pos_reg;
                                av_en     = 1'b1;
                            end
                            else
                            begin
                                kind_next  = VK_SCALAR;
                                phase_next = PH_VALUE;
                            end
                        end
                    end
                    PH_VALUE:
                    begin
                        case (kind_reg)
                            VK_SCALAR:
                            begin
                                if (data_byte inside {CH_COMMA, CH_RBRACE, CH_RBRACKET}
                                    || is_ws(data_byte))
                                begin
                                    fin_en  = 1'b1;
                                    fin_end = pos_reg;
                                    av_en   = 1'b1;
                                end
                            end
                            VK_STRING, VK_CONT_STRING:
                            begin
                                if (esc_reg)
                                    esc_next = 1'b0;
                                else if (data_byte == CH_BACKSLASH)
                                    esc_next = 1'b1;
                                else if (data_byte == CH_QUOTE)
                                begin
                                    if (kind_reg == VK_STRING)
                                    begin
                                        fin_en  = 1'b1;
                                        fin_end = pos_reg + POS_W'(1);
                                    end
                                    else
                                        kind_next = VK_CONTAINER;
                                end
                            end
                            default:
                            begin
                                if (data_byte == CH_QUOTE)
                                    kind_next = VK_CONT_STRING;
                                else if (data_byte inside {CH_LBRACE, CH_LBRACKET})
                                begin
                                    if (depth_reg >= DEPTH_W'(MAX_DEPTH))
                                        fail_code = STATUS_BOUND;
                                    else
                                        depth_next = depth_reg + DEPTH_W'(1);
                                end
                                else if (data_byte inside {CH_RBRACE, CH_RBRACKET})
                                begin
                                    depth_next = depth_reg - DEPTH_W'(1);
                                    if (depth_reg == DEPTH_W'(1))
                                    begin
                                        fin_en  = 1'b1;
                                        fin_end = pos_reg + POS_W'(1);
                                    end
                                end
                            end
                        endcase
                    end
                    PH_AFTER_VALUE:
                        av_en = 1'b1;
                    PH_AFTER_CLOSE:
                    begin
                        if (!is_ws(data_byte))
                            fail_code = STATUS_MALFORMED;
                    end
                    default:
                    begin
                    end
                endcase

                if (fin_en)
                begin
                    fin_len = fin_end - vstart_next;
                    if (kind_next == VK_STRING && flags_reg[0])
                    begin
                        prov_start_next = vstart_next + POS_W'(1);
                        prov_size_next  = fin_len - POS_W'(2);
                        prov_found_next = 1'b1;
                    end
                    else if (flags_reg[1])
                    begin
                        pay_start_next = vstart_next;
                        pay_size_next  = fin_len;
                        pay_found_next = 1'b1;
                    end
                    phase_next = PH_AFTER_VALUE;
                end

                if (av_en && !is_ws(data_byte))
                begin
                    if (data_byte == CH_COMMA)
                        phase_next = PH_MEMBER;
                    else if (data_byte == CH_RBRACE)
                        phase_next = PH_AFTER_CLOSE;
                    else
                        fail_code = STATUS_MALFORMED;
                end

                if (fail_code != STATUS_OK)
                begin
                    if (fail_code > err_reg)
                        err_next = fail_code;
                    phase_next = PH_HALT;
                end
            end

            if (last_byte)
            begin
                frame_status = err_next;
                if (frame_status == STATUS_OK
                    && (phase_next != PH_AFTER_CLOSE || !prov_found_next
                        || prov_size_next == '0 || !pay_found_next))
                    frame_status = STATUS_MALFORMED;

                out_valid_next = 1'b1;
                status_next    = frame_status;
                if (frame_status == STATUS_OK)
                begin
                    prov_off_next = OUT_W'(prov_start_next);
                    prov_len_next = OUT_W'(prov_size_next);
                    pay_off_next  = OUT_W'(pay_start_next);
                    pay_len_next  = OUT_W'(pay_size_next);
                end
                else
                begin
                    prov_off_next = '0;
                    prov_len_next = '0;
                    pay_off_next  = '0;
                    pay_len_next  = '0;
                end

                phase_next      = PH_BEFORE_OPEN;
                pos_next        = '0;
                esc_next        = 1'b0;
                kind_next       = VK_SCALAR;
                depth_next      = '0;
                key_len_next    = '0;
                flags_next      = '0;
                vstart_next     = '0;
                prov_start_next = '0;
                prov_size_next  = '0;
                prov_found_next = 1'b0;
                pay_start_next  = '0;
                pay_size_next   = '0;
                pay_found_next  = 1'b0;
                err_next        = STATUS_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_BEFORE_OPEN;
            pos_reg        <= '0;
            esc_reg        <= 1'b0;
            kind_reg       <= VK_SCALAR;
            depth_reg      <= '0;
            key_len_reg    <= '0;
            flags_reg      <= '0;
            vstart_reg     <= '0;
            prov_start_reg <= '0;
            prov_size_reg  <= '0;
            prov_found_reg <= 1'b0;
            pay_start_reg  <= '0;
            pay_size_reg   <= '0;
            pay_found_reg  <= 1'b0;
            err_reg        <= STATUS_OK;
            out_valid_reg  <= 1'b0;
            status_reg     <= STATUS_OK;
            prov_off_reg   <= '0;
            prov_len_reg   <= '0;
            pay_off_reg    <= '0;
            pay_len_reg    <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            pos_reg        <= pos_next;
            esc_reg        <= esc_next;
            kind_reg       <= kind_next;
            depth_reg      <= depth_next;
            key_len_reg    <= key_len_next;
            flags_reg      <= flags_next;
            vstart_reg     <= vstart_next;
            prov_start_reg <= prov_start_next;
            prov_size_reg  <= prov_size_next;
            prov_found_reg <= prov_found_next;
            pay_start_reg  <= pay_start_next;
            pay_size_reg   <= pay_size_next;
            pay_found_reg  <= pay_found_next;
            err_reg        <= err_next;
            out_valid_reg  <= out_valid_next;
            status_reg     <= status_next;
            prov_off_reg   <= prov_off_next;
            prov_len_reg   <= prov_len_next;
            pay_off_reg    <= pay_off_next;
            pay_len_reg    <= pay_len_next;
        end
    end

    `JEMS_ASSERT(a_last_gives_result,
        in_valid && !in_stall && last_byte |=> out_valid_reg,
        "last beat did not produce a result")
    `JEMS_ASSERT(a_last_clears_parser,
        in_valid && !in_stall && last_byte |=> phase_reg == PH_BEFORE_OPEN
            && pos_reg == '0 && err_reg == STATUS_OK,
        "parser not cleared after frame")
    `JEMS_ASSERT(a_error_zero_fields,
        out_valid_reg && status_reg != STATUS_OK |-> prov_off_reg == '0
            && prov_len_reg == '0 && pay_off_reg == '0 && pay_len_reg == '0,
        "error result carries nonzero fields")
    `JEMS_ASSERT(a_ok_has_provider,
        out_valid_reg && status_reg == STATUS_OK |-> prov_len_reg != '0,
        "ok result with empty provider")
    `JEMS_ASSERT_ALWAYS(a_depth_bound, depth_reg <= DEPTH_W'(MAX_DEPTH),
        "nesting depth beyond bound")

endmodule

`default_nettype wire
